@@ hw/rtl/rsa_pkg.sv @@
// shared types and constants for the refcounted slot allocator
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int SLOTS_DEF   = 1024;
  localparam int HANDLE_W    = 10;
  localparam int HANDLE_SPAN = 1 << HANDLE_W;
  localparam int COUNT_W     = 32;
  localparam int GEN_W       = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int IN_DATA_W   = 16;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 80;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_REF   = 2'd1,
    FN_UNREF = 2'd2,
    FN_QUERY = 2'd3
  } func_e_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_FULL = 3'd1,
    ST_NULL = 3'd2,
    ST_DEAD = 3'd3,
    ST_SAT  = 3'd4
  } status_e_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_t;

  // classified command passed from front to back
  typedef struct packed {
    func_e_t               func;
    logic [HANDLE_W-1:0]   handle;
    logic                  is_null;
    logic                  in_range;
  } cmd_t;

  // one slot table entry
  typedef struct packed {
    logic [GEN_W-1:0]   gen;
    logic [COUNT_W-1:0] count;
  } slot_t;

  // one result beat
  typedef struct packed {
    status_e_t           status;
    logic                released;
    logic [GEN_W-1:0]    gen;
    logic [COUNT_W-1:0]  count;
    logic [HANDLE_W-1:0] handle;
  } res_t;

endpackage

@@ hw/rtl/rsa_ram.sv @@
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps

module rsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/rsa_fifo.sv @@
// short command queue between front and back
`timescale 1ns / 1ps

module rsa_fifo
  import rsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign full     = (fill == (PW+1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + (PW+1)'(1);
        2'b01:   fill <= fill - (PW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ hw/rtl/rsa_front.sv @@
// input side: takes beats and classifies the handle
`timescale 1ns / 1ps

module rsa_front
  import rsa_pkg::*;
#(
  parameter int SLOT_DEPTH = SLOTS_DEF
) (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [IN_USER_W-1:0] s_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_data
);

  logic [HANDLE_W-1:0] handle;

  assign handle   = s_tdata[HANDLE_W-1:0];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_data          = '0;
    q_data.func     = func_e_t'(s_tuser);
    q_data.handle   = handle;
    q_data.is_null  = (handle == '0);
    // handles past the table size can never be live
    q_data.in_range = ({1'b0, handle} < (HANDLE_W+1)'(SLOT_DEPTH));
  end

endmodule

@@ hw/rtl/rsa_back.sv @@
// execution side: read-modify-write of slot table and free stack
`timescale 1ns / 1ps

module rsa_back
  import rsa_pkg::*;
#(
  parameter int SLOT_DEPTH = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  cmd_t q_data,
  output logic q_pop,
  output logic m_tvalid,
  input  logic m_tready,
  output res_t res
);

  localparam int AW = $clog2(SLOT_DEPTH);

  back_state_t          state, state_next;
  cmd_t                 cmd, cmd_next;
  logic [AW-1:0]        free_top, free_top_next;
  logic [AW-1:0]        high_water, high_water_next;
  logic [GEN_W-1:0]     gen_counter, gen_counter_next;
  logic                 out_valid, out_valid_next;
  res_t                 res_next;

  logic                 slot_we;
  logic [AW-1:0]        slot_waddr, slot_raddr;
  slot_t                slot_wdata, slot_rdata;
  logic                 stk_we;
  logic [AW-1:0]        stk_wdata, stk_rdata;

  logic [AW-1:0]        hidx;
  logic [AW-1:0]        new_slot;
  logic [GEN_W-1:0]     gen_inc, gen_new;
  logic                 live;
  logic                 can_load;

  rsa_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOT_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  rsa_ram #(.WIDTH(AW), .DEPTH(SLOT_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (free_top),
    .wdata (stk_wdata),
    .raddr (free_top - AW'(1)),
    .rdata (stk_rdata)
  );

  assign m_tvalid   = out_valid;
  assign can_load   = !out_valid || m_tready;
  assign hidx       = cmd.handle[AW-1:0];
  assign slot_raddr = (state == BK_IDLE) ? q_data.handle[AW-1:0] : hidx;
  assign gen_inc    = gen_counter + GEN_W'(1);
  assign gen_new    = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  // slots above the high-water mark hold no entry written since reset and read as dead
  assign live       = cmd.in_range && (hidx <= high_water) && (slot_rdata.gen != '0);

  always_comb begin
    state_next       = state;
    cmd_next         = cmd;
    q_pop            = 1'b0;
    free_top_next    = free_top;
    high_water_next  = high_water;
    gen_counter_next = gen_counter;
    out_valid_next   = out_valid && !m_tready;
    res_next         = res;
    slot_we          = 1'b0;
    slot_waddr       = hidx;
    slot_wdata       = '0;
    stk_we           = 1'b0;
    stk_wdata        = hidx;
    new_slot         = high_water + AW'(1);

    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cmd_next   = q_data;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (can_load) begin
          state_next     = BK_IDLE;
          out_valid_next = 1'b1;
          res_next       = '0;
          if (cmd.func == FN_ALLOC) begin
            if (free_top != '0 || high_water != AW'(SLOT_DEPTH - 1)) begin
              if (free_top != '0) begin
                new_slot      = stk_rdata;
                free_top_next = free_top - AW'(1);
              end else begin
                high_water_next = new_slot;
              end
              gen_counter_next = gen_new;
              slot_we          = 1'b1;
              slot_waddr       = new_slot;
              slot_wdata.gen   = gen_new;
              slot_wdata.count = COUNT_W'(1);
              res_next.handle  = HANDLE_W'(new_slot);
              res_next.count   = COUNT_W'(1);
              res_next.gen     = gen_new;
              res_next.status  = ST_OK;
            end else begin
              res_next.status = ST_FULL;
            end
          end else if (cmd.is_null) begin
            res_next.status = ST_NULL;
          end else if (!live) begin
            res_next.status = ST_DEAD;
          end else begin
            res_next.handle = cmd.handle;
            res_next.gen    = slot_rdata.gen;
            res_next.count  = slot_rdata.count;
            res_next.status = ST_OK;
            case (cmd.func)
              FN_REF: begin
                if (slot_rdata.count == '1) begin
                  res_next.status = ST_SAT;
                end else begin
                  slot_we          = 1'b1;
                  slot_wdata.gen   = slot_rdata.gen;
                  slot_wdata.count = slot_rdata.count + COUNT_W'(1);
                  res_next.count   = slot_wdata.count;
                end
              end
              FN_UNREF: begin
                slot_we = 1'b1;
                if (slot_rdata.count <= COUNT_W'(1)) begin
                  // last reference gone: kill the slot and recycle it
                  stk_we            = 1'b1;
                  free_top_next     = free_top + AW'(1);
                  res_next.count    = '0;
                  res_next.gen      = '0;
                  res_next.released = 1'b1;
                end else begin
                  slot_wdata.gen   = slot_rdata.gen;
                  slot_wdata.count = slot_rdata.count - COUNT_W'(1);
                  res_next.count   = slot_wdata.count;
                end
              end
              default: begin
                res_next.status = ST_OK;
              end
            endcase
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      free_top    <= '0;
      high_water  <= '0;
      gen_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      free_top    <= free_top_next;
      high_water  <= high_water_next;
      gen_counter <= gen_counter_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    res <= res_next;
  end

endmodule

@@ hw/rtl/refcounted_slot_allocator.sv @@
// top level of the refcounted slot allocator
`timescale 1ns / 1ps

// Generational handle table with reference counts. Each input beat carries an
// operation in s_tuser (allocate, add reference, drop reference, query) and a
// handle in s_tdata; each produces exactly one result beat on the m_ side with
// the handle, count, generation, a release flag and a status code. Handle 0
// is null. The front stage classifies beats into a two-entry command queue,
// so input beats are still taken while a result waits on m_tready, until the
// queue fills. The back stage owns all state: its idle state pops a command
// and reads the slot entry and free-stack top from synchronous ram, its exec
// state updates them and loads the output register once free; no new command
// is taken before that slot ram read-modify-write ends. Slots above the
// high-water mark read as dead, so no clearing pass is needed after reset.
module refcounted_slot_allocator
  import rsa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] handle, rest zero
  input  logic [IN_USER_W-1:0]  s_tuser,   // [1:0] func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [9:0] result_handle, [41:10] count,
                                           // [73:42] generation, [74] released,
                                           // [77:75] status, rest zero
);

  // usable table size: a 10-bit handle names no more than this
  localparam int SLOT_DEPTH = (SLOTS < HANDLE_SPAN) ? SLOTS : HANDLE_SPAN;

  cmd_t q_in, q_out;
  logic q_push, q_pop, q_full, q_empty;
  res_t res;

  rsa_front #(.SLOT_DEPTH(SLOT_DEPTH)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // decouples beat intake from table updates
  rsa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  rsa_back #(.SLOT_DEPTH(SLOT_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  // pack result fields, first field in the lowest bits
  assign m_tdata = {2'b00, res.status, res.released, res.gen, res.count, res.handle};

endmodule

@@ hw/rtl/rsa_checker.sv @@
// port-level checks for the refcounted slot allocator, bound to the top level
`timescale 1ns / 1ps

module rsa_checker
  import rsa_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic [HANDLE_W-1:0] o_handle;
  logic [COUNT_W-1:0]  o_count;
  logic [GEN_W-1:0]    o_gen;
  logic                o_rel;
  logic [2:0]          o_status;

  assign o_handle = m_tdata[9:0];
  assign o_count  = m_tdata[41:10];
  assign o_gen    = m_tdata[73:42];
  assign o_rel    = m_tdata[74];
  assign o_status = m_tdata[77:75];

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (o_status == ST_FULL || o_status == ST_NULL || o_status == ST_DEAD)
      |-> o_handle == '0 && o_count == '0 && o_gen == '0 && !o_rel)
    else $error("failed operation returned nonzero fields");

  a_release_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_rel |-> o_status == ST_OK && o_gen == '0 && o_count == '0
      && o_handle != '0)
    else $error("release beat malformed");

  a_live_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (o_status == ST_OK || o_status == ST_SAT) && !o_rel
      |-> o_handle != '0 && o_gen != '0 && o_count != '0)
    else $error("live result with null handle, generation or count");

endmodule

bind refcounted_slot_allocator rsa_checker u_rsa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
